[src/wpr_pkg.sv]
package wpr_pkg;

  // width of the delivered-sample counter
  localparam int CountBits = 24;
  // common width for the limit compare against the 24-bit register
  localparam int CmpBits   = (CountBits > 24) ? CountBits : 24;

  localparam int HdrLen    = 44;
  localparam int PosBits   = $clog2(HdrLen + 1);

  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWave = "WAVE";
  localparam logic [31:0] TagFmt  = "fmt ";
  localparam logic [31:0] TagData = "data";

  localparam logic [31:0] RateHz     = 32'd44100;
  localparam logic [15:0] SampleBits = 16'd16;
  localparam logic [15:0] ChanMono   = 16'd1;
  localparam logic [15:0] ChanStereo = 16'd2;

  localparam logic [23:0] MaxSamplesRst = 24'hFF_FFFF;
  localparam logic [2:0]  AddrMaxSamples = 3'd0;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PhHeader,
    PhData,
    PhReject
  } phase_e;

  // one entry between the parser and the output stage
  typedef struct packed {
    logic        have;
    logic        stereo;
    logic [15:0] left;
    logic [15:0] right;
    logic        eof;
    logic        hdr_ok;
    logic [23:0] total;
  } item_t;

  // expected tag byte for a header position: {check, byte}
  function automatic logic [8:0] hdr_tag(input logic [PosBits-1:0] pos);
    logic [31:0] tag;
    logic        chk;
    logic [4:0]  sel;
    tag = '0;
    chk = 1'b0;
    if (pos inside {[0:3]}) begin
      tag = TagRiff;
      chk = 1'b1;
    end else if (pos inside {[8:11]}) begin
      tag = TagWave;
      chk = 1'b1;
    end else if (pos inside {[12:15]}) begin
      tag = TagFmt;
      chk = 1'b1;
    end else if (pos inside {[36:39]}) begin
      tag = TagData;
      chk = 1'b1;
    end
    // first character sits in the top byte of the literal
    sel = {~pos[1:0], 3'b000};
    return {chk, tag[sel +: 8]};
  endfunction

endpackage

[src/wpr_front.sv]
module wpr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  input  logic                 eof_i,
  input  logic [23:0]          max_samples_i,
  output logic                 push_o,
  output wpr_pkg::item_t       item_o
);

  wpr_pkg::phase_e               phase_q, phase_d;
  logic [wpr_pkg::PosBits-1:0]   pos_q, pos_d;
  logic                          good_q, good_d;
  logic [15:0]                   chan_q, chan_d;
  logic [31:0]                   rate_q, rate_d;
  logic [15:0]                   bits_q, bits_d;
  logic [7:0]                    low_q, low_d;
  logic [1:0]                    fidx_q, fidx_d;
  logic [15:0]                   left_q, left_d;
  logic [wpr_pkg::CountBits-1:0] count_q, count_d;

  logic        have;
  logic        stereo;
  logic [15:0] left_w;
  logic [15:0] right_w;
  logic        good_w;
  logic [8:0]  tag_w;
  logic        room;

  assign tag_w = wpr_pkg::hdr_tag(pos_q);
  assign room  = (wpr_pkg::CmpBits'(count_q) < wpr_pkg::CmpBits'(max_samples_i)) &&
                 (count_q != '1);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    good_d  = good_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    low_d   = low_q;
    fidx_d  = fidx_q;
    left_d  = left_q;
    count_d = count_q;
    have    = 1'b0;
    stereo  = 1'b0;
    left_w  = '0;
    right_w = '0;
    good_w  = good_q;

    case (phase_q)
      wpr_pkg::PhHeader: begin
        if (tag_w[8] && (tag_w[7:0] != byte_i)) good_w = 1'b0;
        if (pos_q inside {[22:23]}) chan_d[{pos_q[0], 3'b000} +: 8] = byte_i;
        if (pos_q inside {[24:27]}) rate_d[{pos_q[1:0], 3'b000} +: 8] = byte_i;
        if (pos_q inside {[34:35]}) bits_d[{pos_q[0], 3'b000} +: 8] = byte_i;
        pos_d = pos_q + 1'b1;
        if (pos_q == wpr_pkg::PosBits'(wpr_pkg::HdrLen - 1)) begin
          if (!((chan_q == wpr_pkg::ChanMono) || (chan_q == wpr_pkg::ChanStereo)))
            good_w = 1'b0;
          if (rate_q != wpr_pkg::RateHz) good_w = 1'b0;
          if (bits_q != wpr_pkg::SampleBits) good_w = 1'b0;
          phase_d = good_w ? wpr_pkg::PhData : wpr_pkg::PhReject;
          fidx_d  = 2'd0;
        end
        good_d = good_w;
      end
      wpr_pkg::PhData: begin
        if (room) begin
          case (fidx_q)
            2'd0: begin
              low_d  = byte_i;
              fidx_d = 2'd1;
            end
            2'd1: begin
              left_d = {byte_i, low_q};
              if (chan_q == wpr_pkg::ChanMono) begin
                have   = 1'b1;
                left_w = {byte_i, low_q};
                fidx_d = 2'd0;
              end else begin
                fidx_d = 2'd2;
              end
            end
            2'd2: begin
              low_d  = byte_i;
              fidx_d = 2'd3;
            end
            default: begin
              have    = 1'b1;
              stereo  = 1'b1;
              left_w  = left_q;
              right_w = {byte_i, low_q};
              fidx_d  = 2'd0;
            end
          endcase
          if (have) count_d = count_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    item_o.have   = have;
    item_o.stereo = stereo;
    item_o.left   = left_w;
    item_o.right  = right_w;
    item_o.eof    = eof_i;
    item_o.hdr_ok = (phase_d == wpr_pkg::PhData);
    item_o.total  = 24'(count_d);

    // last byte of a file: start over for the next one
    if (eof_i) begin
      phase_d = wpr_pkg::PhHeader;
      pos_d   = '0;
      good_d  = 1'b1;
      chan_d  = '0;
      rate_d  = '0;
      bits_d  = '0;
      low_d   = '0;
      fidx_d  = 2'd0;
      left_d  = '0;
      count_d = '0;
    end
  end

  assign push_o = take_i & (have | eof_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpr_pkg::PhHeader;
      pos_q   <= '0;
      good_q  <= 1'b1;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      low_q   <= '0;
      fidx_q  <= 2'd0;
      left_q  <= '0;
      count_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      good_q  <= good_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      low_q   <= low_d;
      fidx_q  <= fidx_d;
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

endmodule

[src/wpr_queue.sv]
module wpr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wpr_pkg::item_t item_i,
  input  logic           pop_i,
  output wpr_pkg::item_t item_o,
  output logic           full_o,
  output logic           avail_o
);

  wpr_pkg::item_t            mem_q [wpr_pkg::QDepth];
  logic [wpr_pkg::QPtrW-1:0] wr_q, wr_d;
  logic [wpr_pkg::QPtrW-1:0] rd_q, rd_d;
  logic [wpr_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                      do_push;
  logic                      do_pop;

  assign full_o  = (cnt_q == wpr_pkg::QCntW'(wpr_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & avail_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push)
      wr_d = (wr_q == wpr_pkg::QPtrW'(wpr_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)
      rd_d = (rd_q == wpr_pkg::QPtrW'(wpr_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

[src/wpr_back.sv]
module wpr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  wpr_pkg::item_t item_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [15:0]    sample_o,
  output logic           sample_valid_o,
  output logic           finished_o,
  output logic           header_ok_o,
  output logic [23:0]    sample_total_o
);

  logic        valid_q, valid_d;
  logic [15:0] sample_q;
  logic        have_q;
  logic        last_q;
  logic        hok_q;
  logic [23:0] total_q;

  logic        load;
  logic [16:0] sum;
  logic [16:0] adj;
  logic [16:0] avg;
  logic [16:0] clamped;
  logic [15:0] sample_w;

  // average rounds toward zero: bump odd negative sums before the shift
  assign sum = {item_i.left[15], item_i.left} + {item_i.right[15], item_i.right};
  assign adj = sum + 17'(sum[16] & sum[0]);

  always_comb begin
    if (item_i.stereo) avg = {adj[16], adj[16:1]};
    else               avg = {item_i.left[15], item_i.left};
    // only the most negative code needs clamping
    if (avg == 17'h1_8000) clamped = 17'h1_8001;
    else                   clamped = avg;
    sample_w = item_i.have ? clamped[15:0] : 16'd0;
  end

  assign load  = avail_i & (~valid_q | ready_i);
  assign pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load)         valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_w;
      have_q   <= item_i.have;
      last_q   <= item_i.eof;
      hok_q    <= item_i.hdr_ok;
      total_q  <= item_i.total;
    end
  end

  assign valid_o        = valid_q;
  assign sample_o       = sample_q;
  assign sample_valid_o = have_q;
  assign finished_o     = last_q;
  assign header_ok_o    = hok_q;
  assign sample_total_o = total_q;

endmodule

[src/wav_pcm16_reader.sv]
// channel   dir  width  contents
// s_axis    in   8+1    tdata: data_byte; tlast: end_of_file
// m_axis    out  48+2   tdata: sample, header_ok, sample_total; tuser: sample_valid;
//                       tlast: finished
// apb       in   32     max_samples at byte address 0
//
// one byte is accepted per cycle while the queue has room; a result passes through
// the two-entry queue and then the output register
// the parser takes a byte whenever the queue has room, so a stalled output fills the
// queue and then holds s_axis_tready low
// reset is asynchronous and takes effect at once; no clearing pass
module wav_pcm16_reader (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] sample, [16] header_ok, [40:17] sample_total
  output logic        m_axis_tuser,   // [0] sample_valid
  output logic        m_axis_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0]    max_q;
  logic           cfg_wr;
  logic           take;
  logic           push;
  logic           pop;
  logic           full;
  logic           avail;
  wpr_pkg::item_t item_in;
  wpr_pkg::item_t item_out;
  logic [15:0]    sample;
  logic           header_ok;
  logic [23:0]    sample_total;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == wpr_pkg::AddrMaxSamples[2]);
  assign prdata = (paddr[2] == wpr_pkg::AddrMaxSamples[2]) ? {8'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     max_q <= wpr_pkg::MaxSamplesRst;
    else if (cfg_wr) max_q <= pwdata[23:0];
  end

  assign s_axis_tready = ~full;
  assign take          = s_axis_tvalid & ~full;

  wpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_i       (s_axis_tdata),
    .eof_i        (s_axis_tlast),
    .max_samples_i(max_q),
    .push_o       (push),
    .item_o       (item_in)
  );

  wpr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_in),
    .pop_i  (pop),
    .item_o (item_out),
    .full_o (full),
    .avail_o(avail)
  );

  wpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .item_i        (item_out),
    .pop_o         (pop),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .sample_o      (sample),
    .sample_valid_o(m_axis_tuser),
    .finished_o    (m_axis_tlast),
    .header_ok_o   (header_ok),
    .sample_total_o(sample_total)
  );

  assign m_axis_tdata = {7'd0, sample_total, header_ok, sample};

endmodule

[src/wpr_checker.sv]
module wpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a result with no sample must be the end of a file
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("result without sample or end of file");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("sample field not zero on empty result");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
    else $error("sample not clamped");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

endmodule

bind wav_pcm16_reader wpr_checker u_wpr_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int RandBytes   = 1150;
  localparam int NumPhases   = 6;
  localparam int PcmMax      = 32767;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wav_byte_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        valid;
    logic        fin;
    logic        hdr_ok;
    logic [23:0] total;
  } pcm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // end_of_file

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] sample, [16] header_ok, [40:17] sample_total
  logic        m_axis_tuser;        // [0] sample_valid
  logic        m_axis_tlast;        // finished

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wav_pcm16_reader dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  wav_byte_t   wav_bytes_q[$];
  pcm_result_t pcm_due_q[$];
  logic [7:0]  file_q[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int n_bytes = 0;
  int n_queued = 0;
  int n_files = 0;
  int n_rejected = 0;
  int n_samples = 0;
  int n_limits = 0;
  bit byte_taken = 1'b0;

  // parser mirror
  logic [23:0]                   limit_reg = wpr_pkg::MaxSamplesRst;
  wpr_pkg::phase_e               rd_phase = wpr_pkg::PhHeader;
  int                            hdr_pos = 0;
  bit                            hdr_pass = 1'b1;
  logic [15:0]                   chan_cnt = '0;
  logic [31:0]                   rate_val = '0;
  logic [15:0]                   bps_val = '0;
  logic [7:0]                    lo_hold = '0;
  logic [1:0]                    frame_idx = '0;
  logic [15:0]                   left_hold = '0;
  logic [wpr_pkg::CountBits-1:0] out_count = '0;

  task automatic clear_parser();
    rd_phase  = wpr_pkg::PhHeader;
    hdr_pos   = 0;
    hdr_pass  = 1'b1;
    chan_cnt  = '0;
    rate_val  = '0;
    bps_val   = '0;
    lo_hold   = '0;
    frame_idx = '0;
    left_hold = '0;
    out_count = '0;
  endtask

  task automatic parse_wav_byte(input logic [7:0] b, input logic eof);
    logic [31:0] tag;
    int          base;
    int          sl;
    int          sr;
    int          s;
    bit          have;
    bit          chk;
    pcm_result_t r;
    have = 1'b0;
    chk  = 1'b0;
    s    = 0;
    tag  = '0;
    base = 0;
    case (rd_phase)
      wpr_pkg::PhHeader: begin
        if (hdr_pos < 4) begin
          tag = wpr_pkg::TagRiff; base = 0; chk = 1'b1;
        end else if (hdr_pos >= 8 && hdr_pos < 12) begin
          tag = wpr_pkg::TagWave; base = 8; chk = 1'b1;
        end else if (hdr_pos >= 12 && hdr_pos < 16) begin
          tag = wpr_pkg::TagFmt; base = 12; chk = 1'b1;
        end else if (hdr_pos >= 36 && hdr_pos < 40) begin
          tag = wpr_pkg::TagData; base = 36; chk = 1'b1;
        end
        // tag text starts in the top byte of the word
        if (chk && tag[31 - 8 * (hdr_pos - base) -: 8] != b) hdr_pass = 1'b0;
        if (hdr_pos >= 22 && hdr_pos < 24) chan_cnt[8 * (hdr_pos - 22) +: 8] = b;
        if (hdr_pos >= 24 && hdr_pos < 28) rate_val[8 * (hdr_pos - 24) +: 8] = b;
        if (hdr_pos >= 34 && hdr_pos < 36) bps_val[8 * (hdr_pos - 34) +: 8] = b;
        hdr_pos++;
        if (hdr_pos >= wpr_pkg::HdrLen) begin
          if (chan_cnt == '0 || chan_cnt > wpr_pkg::ChanStereo) hdr_pass = 1'b0;
          if (rate_val != wpr_pkg::RateHz) hdr_pass = 1'b0;
          if (bps_val != wpr_pkg::SampleBits) hdr_pass = 1'b0;
          rd_phase  = hdr_pass ? wpr_pkg::PhData : wpr_pkg::PhReject;
          frame_idx = '0;
        end
      end
      wpr_pkg::PhData: begin
        if (out_count < limit_reg && out_count != '1) begin
          case (frame_idx)
            2'd0: begin
              lo_hold   = b;
              frame_idx = 2'd1;
            end
            2'd1: begin
              left_hold = {b, lo_hold};
              if (chan_cnt == wpr_pkg::ChanMono) begin
                s         = $signed(left_hold);
                have      = 1'b1;
                frame_idx = 2'd0;
              end else begin
                frame_idx = 2'd2;
              end
            end
            2'd2: begin
              lo_hold   = b;
              frame_idx = 2'd3;
            end
            default: begin
              sl        = $signed(left_hold);
              sr        = $signed({b, lo_hold});
              s         = (sl + sr) / 2;
              have      = 1'b1;
              frame_idx = 2'd0;
            end
          endcase
          if (have) begin
            if (s > PcmMax) s = PcmMax;
            if (s < -PcmMax) s = -PcmMax;
            out_count++;
          end
        end
      end
      default: ;
    endcase
    if (have || eof) begin
      r.sample = have ? 16'(s) : 16'h0000;
      r.valid  = have;
      r.fin    = eof;
      r.hdr_ok = (rd_phase == wpr_pkg::PhData);
      r.total  = 24'(out_count);
      pcm_due_q.push_back(r);
    end
    if (eof) begin
      n_files++;
      if (rd_phase != wpr_pkg::PhData) n_rejected++;
      clear_parser();
    end
  endtask

  // input side: transaction bookkeeping at the rising edge
  always @(posedge clk_i) begin
    byte_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      n_bytes++;
      parse_wav_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // driver and sink stalls change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      if (wav_bytes_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wav_bytes_q[0].data;
        s_axis_tlast  <= wav_bytes_q[0].last;
        void'(wav_bytes_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin : pcm_monitor
    pcm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pcm_due_q.size() == 0) begin
        $error("unexpected transaction: tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_cnt++;
      end else begin
        want = pcm_due_q.pop_front();
        if (m_axis_tuser) n_samples++;
        if (m_axis_tdata[15:0] !== want.sample) begin
          $error("sample: expected %0d, actual %0d",
                 $signed(want.sample), $signed(m_axis_tdata[15:0]));
          err_cnt++;
        end
        if (m_axis_tuser !== want.valid) begin
          $error("sample_valid: expected %b, actual %b", want.valid, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tlast !== want.fin) begin
          $error("finished: expected %b, actual %b", want.fin, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tdata[16] !== want.hdr_ok) begin
          $error("header_ok: expected %b, actual %b", want.hdr_ok, m_axis_tdata[16]);
          err_cnt++;
        end
        if (m_axis_tdata[40:17] !== want.total) begin
          $error("sample_total: expected %0d, actual %0d", want.total, m_axis_tdata[40:17]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_limit(input logic [23:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= wpr_pkg::AddrMaxSamples;
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_reg = v;
    n_limits++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (wav_bytes_q.size() != 0 || s_axis_tvalid || pcm_due_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_header(input logic [15:0] chans, input logic [31:0] rate,
                             input logic [15:0] bps);
    logic [7:0] hb [wpr_pkg::HdrLen];
    for (int i = 0; i < wpr_pkg::HdrLen; i++) hb[i] = 8'($urandom());
    for (int i = 0; i < 4; i++) begin
      hb[i]      = wpr_pkg::TagRiff[31 - 8 * i -: 8];
      hb[8 + i]  = wpr_pkg::TagWave[31 - 8 * i -: 8];
      hb[12 + i] = wpr_pkg::TagFmt[31 - 8 * i -: 8];
      hb[36 + i] = wpr_pkg::TagData[31 - 8 * i -: 8];
      hb[24 + i] = rate[8 * i +: 8];
    end
    hb[22] = chans[7:0];
    hb[23] = chans[15:8];
    hb[34] = bps[7:0];
    hb[35] = bps[15:8];
    for (int i = 0; i < wpr_pkg::HdrLen; i++) file_q.push_back(hb[i]);
  endtask

  task automatic push_pcm(input logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic send_file();
    n_queued += file_q.size();
    foreach (file_q[i])
      wav_bytes_q.push_back(wav_byte_t'{data: file_q[i], last: (i == file_q.size() - 1)});
    file_q.delete();
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h7F;
        default: return 8'h80;
      endcase
    end
    return 8'($urandom());
  endfunction

  // mostly clean headers with random sample data; the rest broken or cut short
  task automatic queue_random_file();
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bps;
    int          roll;
    int          idx;
    int          pos;
    int          len;
    chans = 16'($urandom_range(1, 2));
    rate  = wpr_pkg::RateHz;
    bps   = wpr_pkg::SampleBits;
    roll  = $urandom_range(99);
    if (roll >= 8 && roll < 11) chans = '0;
    else if (roll >= 11 && roll < 14) chans = 16'($urandom_range(3, 16'hFFFF));
    else if (roll >= 14 && roll < 17) rate = wpr_pkg::RateHz ^ (32'd1 << $urandom_range(31));
    else if (roll >= 17 && roll < 20) bps = wpr_pkg::SampleBits ^ (16'd1 << $urandom_range(15));
    push_header(chans, rate, bps);
    if (roll < 8) begin
      idx = $urandom_range(15);
      pos = (idx < 4) ? idx : (idx < 12) ? idx + 4 : idx + 24;
      file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
    end
    if (roll >= 20 && roll < 23) begin
      len = $urandom_range(1, wpr_pkg::HdrLen - 1);
      while (file_q.size() > len) void'(file_q.pop_back());
    end else begin
      len = $urandom_range(0, 48);
      for (int i = 0; i < len; i++) file_q.push_back(pick_byte());
    end
    send_file();
  endtask

  initial begin
    logic [23:0] lim;
    int          base;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_limit(wpr_pkg::MaxSamplesRst);

    // one-byte file ends inside the header
    file_q.push_back(8'h52);
    send_file();
    // mono: full scale, negative overflow, zero, minus one, then a dangling byte
    push_header(wpr_pkg::ChanMono, wpr_pkg::RateHz, wpr_pkg::SampleBits);
    push_pcm(16'h7FFF);
    push_pcm(16'h8000);
    push_pcm(16'h0000);
    push_pcm(16'hFFFF);
    file_q.push_back(8'h12);
    send_file();
    // stereo: clamping, rounding toward zero both ways, partial trailing frame
    push_header(wpr_pkg::ChanStereo, wpr_pkg::RateHz, wpr_pkg::SampleBits);
    push_pcm(16'h7FFF); push_pcm(16'h7FFF);
    push_pcm(16'h8000); push_pcm(16'h8000);
    push_pcm(16'h7FFF); push_pcm(16'h8000);
    push_pcm(16'hFFFF); push_pcm(16'h0000);
    push_pcm(16'h0003); push_pcm(16'h0000);
    push_pcm(16'hFFFD); push_pcm(16'h0000);
    file_q.push_back(8'h34); file_q.push_back(8'h56); file_q.push_back(8'h78);
    send_file();
    // zero channels rejects the header and the data behind it
    push_header(16'h0000, wpr_pkg::RateHz, wpr_pkg::SampleBits);
    push_pcm(16'h1234);
    push_pcm(16'h5678);
    send_file();
    // header only, final byte closes the header
    push_header(wpr_pkg::ChanMono, wpr_pkg::RateHz, wpr_pkg::SampleBits);
    send_file();

    // the random files share what is left of the byte budget
    base = n_queued;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      case (ph)
        0: lim = 24'd0;
        1: lim = 24'd1;
        2: lim = 24'($urandom_range(2, 12));
        3: lim = wpr_pkg::MaxSamplesRst;
        4: lim = 24'($urandom());
        default: lim = 24'($urandom_range(3, 30));
      endcase
      write_limit(lim);
      while (n_queued < base + (ph + 1) * (RandBytes - base) / NumPhases)
        queue_random_file();
    end

    wait_drained();
    if (pcm_due_q.size() != 0) begin
      $error("%0d expected transactions never arrived", pcm_due_q.size());
      err_cnt++;
    end
    $display("covered %0d files (%0d with rejected or short headers), %0d bytes in",
             n_files, n_rejected, n_bytes);
    $display("%0d samples checked under %0d sample limits and four idle mixes",
             n_samples, n_limits);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
